[rtl/tlvdf_pkg.sv]
// Shared types and constants for the TLV record deframer.
`timescale 1ns / 1ps
package tlvdf_pkg;

	localparam int HDR_BYTES = 4;
	localparam int HCNT_W = 2;
	localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HDR_BYTES - 1);
	localparam logic [HCNT_W-1:0] HCNT_TYPE_END = HCNT_W'(1);

	localparam int BYTE_W = 8;
	localparam int FIELD_W = 16;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 3;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TRUNC   = 2'd1,
		ST_OVERRUN = 2'd2
	} status_t;

	typedef struct packed {
		logic [FIELD_W-1:0] record_type;
		logic [FIELD_W-1:0] record_length;
		logic [BYTE_W-1:0]  value_byte;
		logic [FIELD_W-1:0] value_offset;
		logic               value_valid;
		logic               record_end;
		logic               payload_end;
		status_t            status;
	} result_t;

endpackage

[rtl/tlv_record_deframer_core.sv]
// Top level of the TLV record deframer: byte stream in, tagged value bytes out.
//
// Channel   Dir  tdata                         tuser                     tlast
// s_axis    in   [7:0] data_byte               -                         last_byte
// m_axis    out  [15:0] record_type,           [0] value_valid,          payload_end
//                [31:16] record_length,        [2:1] status
//                [39:32] value_byte, [55:40] value_offset, [56] record_end
//
// One byte per cycle sustained while m_axis_tready is high. A transfer is held
// in the input register, decoded combinationally and written to the result
// register. Reset clears the header and value counters; the result register
// holds while a result waits on m_axis_tready, backed up by the input register.
`timescale 1ns / 1ps
module tlv_record_deframer_core
	import tlvdf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // record_type, record_length,
	                                              // value_byte, value_offset,
	                                              // record_end, zero fill
	output logic [OUT_USER_W-1:0] m_axis_tuser,   // value_valid, status
	output logic                  m_axis_tlast
);

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               last_s1;
	logic               advance;

	logic [HCNT_W-1:0]  header_count_q;
	logic               in_value_q;
	logic [FIELD_W-1:0] held_type_q;
	logic [FIELD_W-1:0] held_length_q;
	logic [FIELD_W-1:0] bytes_left_q;
	logic [FIELD_W-1:0] current_offset_q;

	logic [HCNT_W-1:0]  header_count_d;
	logic               in_value_d;
	logic [FIELD_W-1:0] held_type_d;
	logic [FIELD_W-1:0] held_length_d;
	logic [FIELD_W-1:0] bytes_left_d;
	logic [FIELD_W-1:0] current_offset_d;

	result_t            res_d;
	logic               res_en;
	result_t            res_q;
	logic               out_valid_q;
	logic [FIELD_W-1:0] left;
	logic               done;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		header_count_d   = header_count_q;
		in_value_d       = in_value_q;
		held_type_d      = held_type_q;
		held_length_d    = held_length_q;
		bytes_left_d     = bytes_left_q;
		current_offset_d = current_offset_q;
		res_d            = '0;
		res_en           = 1'b0;
		left             = bytes_left_q - FIELD_W'(1);
		done             = (left == '0);

		if (!in_value_q) begin
			if (header_count_q <= HCNT_TYPE_END) begin
				held_type_d = {held_type_q[FIELD_W-BYTE_W-1:0], byte_s1};
			end else begin
				held_length_d = {held_length_q[FIELD_W-BYTE_W-1:0], byte_s1};
			end
			if (header_count_q != HCNT_LAST) begin
				header_count_d = header_count_q + HCNT_W'(1);
				if (last_s1) begin
					res_en            = 1'b1;
					res_d.payload_end = 1'b1;
					res_d.status      = ST_TRUNC;
				end
			end else begin
				header_count_d = '0;
				if (held_length_d == '0) begin
					res_en            = 1'b1;
					res_d.record_type = held_type_d;
					res_d.record_end  = 1'b1;
					res_d.payload_end = last_s1;
					res_d.status      = ST_OK;
					held_type_d       = '0;
				end else if (last_s1) begin
					res_en              = 1'b1;
					res_d.record_type   = held_type_d;
					res_d.record_length = held_length_d;
					res_d.payload_end   = 1'b1;
					res_d.status        = ST_OVERRUN;
				end else begin
					in_value_d       = 1'b1;
					bytes_left_d     = held_length_d;
					current_offset_d = '0;
				end
			end
		end else begin
			res_en              = 1'b1;
			res_d.record_type   = held_type_q;
			res_d.record_length = held_length_q;
			res_d.value_byte    = byte_s1;
			res_d.value_offset  = current_offset_q;
			res_d.value_valid   = 1'b1;
			res_d.record_end    = done;
			res_d.payload_end   = last_s1;
			res_d.status        = (last_s1 && !done) ? ST_OVERRUN : ST_OK;
			bytes_left_d        = left;
			current_offset_d    = current_offset_q + FIELD_W'(1);
			if (done) begin
				in_value_d       = 1'b0;
				held_type_d      = '0;
				held_length_d    = '0;
				current_offset_d = '0;
			end
		end

		if (last_s1) begin
			header_count_d   = '0;
			in_value_d       = 1'b0;
			held_type_d      = '0;
			held_length_d    = '0;
			bytes_left_d     = '0;
			current_offset_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q   <= '0;
			in_value_q       <= 1'b0;
			held_type_q      <= '0;
			held_length_q    <= '0;
			bytes_left_q     <= '0;
			current_offset_q <= '0;
		end else if (advance) begin
			header_count_q   <= header_count_d;
			in_value_q       <= in_value_d;
			held_type_q      <= held_type_d;
			held_length_q    <= held_length_d;
			bytes_left_q     <= bytes_left_d;
			current_offset_q <= current_offset_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_en;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_en) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = res_q.payload_end;
	assign m_axis_tuser  = {res_q.status, res_q.value_valid};
	assign m_axis_tdata  = {{(OUT_DATA_W - 4 * FIELD_W - BYTE_W + FIELD_W - 1){1'b0}},
		res_q.record_end, res_q.value_offset, res_q.value_byte,
		res_q.record_length, res_q.record_type};

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> header_count_q == '0 && !in_value_q)
		else $error("state not cleared after payload end");

	a_value_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_value_q |-> bytes_left_q != '0)
		else $error("value phase with no bytes left");

	a_end_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.record_end |-> res_q.status == ST_OK)
		else $error("completed record flagged with error");

	a_trunc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.status == ST_TRUNC |-> !res_q.value_valid && res_q.payload_end)
		else $error("truncated header result malformed");

endmodule

[bench/tb_tlv_record_deframer_core.sv]
// Testbench for tlv_record_deframer_core: directed and random byte payloads against a predictor.
`timescale 1ns / 1ps
module tb_tlv_record_deframer_core;
	import tlvdf_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEMS_PER_PHASE = 370;
	localparam int SETTLE_CYCLES = 12;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_NONE,
		ROW_RESULT
	} row_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		row_kind_t  kind;
		result_t    res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;

	int src_idle = 28;
	int sink_idle = 52;
	int fails = 0;
	int cycles = 0;
	int bytes_sent = 0;
	int payloads_sent = 0;
	int results_seen = 0;

	result_t  pending_results[$];
	dir_row_t directed_bytes[$];

	logic [1:0]  hdr_count = '0;
	logic        in_val = 1'b0;
	logic [15:0] cur_type = '0;
	logic [15:0] cur_len = '0;
	logic [15:0] remain = '0;
	logic [15:0] next_off = '0;

	tlv_record_deframer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #4 clk = ~clk;

	function automatic result_t mk_res(input logic [15:0] t, input logic [15:0] len,
			input logic [7:0] vb, input logic [15:0] off, input logic vv,
			input logic re, input logic pe, input status_t st);
		result_t r;
		r.record_type = t;
		r.record_length = len;
		r.value_byte = vb;
		r.value_offset = off;
		r.value_valid = vv;
		r.record_end = re;
		r.payload_end = pe;
		r.status = st;
		return r;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b, input logic l,
			output bit has, output result_t r);
		logic [15:0] left;
		has = 1'b0;
		r = '0;
		if (!in_val) begin
			if (hdr_count <= HCNT_TYPE_END)
				cur_type = {cur_type[7:0], b};
			else
				cur_len = {cur_len[7:0], b};
			if (hdr_count != HCNT_LAST) begin
				hdr_count = hdr_count + 2'd1;
				if (l) begin
					has = 1'b1;
					r = mk_res(16'd0, 16'd0, 8'd0, 16'd0, 1'b0, 1'b0, 1'b1, ST_TRUNC);
				end
			end else begin
				hdr_count = '0;
				if (cur_len == 16'd0) begin
					has = 1'b1;
					r = mk_res(cur_type, 16'd0, 8'd0, 16'd0, 1'b0, 1'b1, l, ST_OK);
					cur_type = '0;
				end else if (l) begin
					has = 1'b1;
					r = mk_res(cur_type, cur_len, 8'd0, 16'd0, 1'b0, 1'b0, 1'b1, ST_OVERRUN);
				end else begin
					in_val = 1'b1;
					remain = cur_len;
					next_off = '0;
				end
			end
		end else begin
			left = remain - 16'd1;
			has = 1'b1;
			r = mk_res(cur_type, cur_len, b, next_off, 1'b1, left == 16'd0, l,
				(l && left != 16'd0) ? ST_OVERRUN : ST_OK);
			remain = left;
			next_off = next_off + 16'd1;
			if (left == 16'd0) begin
				in_val = 1'b0;
				cur_type = '0;
				cur_len = '0;
				next_off = '0;
			end
		end
		if (l) begin
			hdr_count = '0;
			in_val = 1'b0;
			cur_type = '0;
			cur_len = '0;
			remain = '0;
			next_off = '0;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l, input row_kind_t kind,
			input result_t fixed_res);
		bit has;
		result_t r;
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= l;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		deframe_byte(b, l, has, r);
		if (kind == ROW_PREDICT && has)
			pending_results.push_back(r);
		else if (kind == ROW_RESULT)
			pending_results.push_back(fixed_res);
		bytes_sent++;
		if (l)
			payloads_sent++;
		@(negedge clk);
	endtask

	task automatic send_payload();
		logic [7:0]  pay[$];
		logic [15:0] t;
		logic [15:0] len;
		int n_rec;
		int pick;
		int cut;
		n_rec = $urandom_range(1, 4);
		for (int i = 0; i < n_rec; i++) begin
			t = 16'($urandom);
			pick = $urandom_range(99);
			if (pick < 15)
				len = 16'd0;
			else if (pick < 85)
				len = 16'($urandom_range(1, 6));
			else
				len = 16'($urandom_range(7, 40));
			pay.push_back(t[15:8]);
			pay.push_back(t[7:0]);
			pay.push_back(len[15:8]);
			pay.push_back(len[7:0]);
			for (int j = 0; j < len; j++)
				pay.push_back(8'($urandom));
		end
		pick = $urandom_range(99);
		if (pick < 75) begin
			cut = pay.size() - 1;
		end else if (pick < 92) begin
			cut = $urandom_range(0, pay.size() - 1);
		end else begin
			pay.delete();
			cut = $urandom_range(0, 11);
			for (int j = 0; j <= cut; j++)
				pay.push_back(8'($urandom));
		end
		for (int j = 0; j <= cut; j++)
			send_byte(pay[j], j == cut, ROW_PREDICT, '0);
	endtask

	function automatic void check_field(input string name, input longint unsigned e,
			input longint unsigned a);
		if (e != a) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, e, a);
			fails++;
		end
	endfunction

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= sink_idle);

	always @(posedge clk) begin : result_monitor
		result_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: tdata 0x%0h tuser 0x%0h",
					m_axis_tdata, m_axis_tuser);
				fails++;
			end else begin
				e = pending_results.pop_front();
				check_field("record_type", 64'(e.record_type), 64'(m_axis_tdata[15:0]));
				check_field("record_length", 64'(e.record_length),
					64'(m_axis_tdata[31:16]));
				check_field("value_byte", 64'(e.value_byte), 64'(m_axis_tdata[39:32]));
				check_field("value_offset", 64'(e.value_offset),
					64'(m_axis_tdata[55:40]));
				check_field("record_end", 64'(e.record_end), 64'(m_axis_tdata[56]));
				check_field("tdata_fill", 64'(0), 64'(m_axis_tdata[63:57]));
				check_field("value_valid", 64'(e.value_valid), 64'(m_axis_tuser[0]));
				check_field("status", 64'(e.status), 64'(m_axis_tuser[2:1]));
				check_field("payload_end", 64'(e.payload_end), 64'(m_axis_tlast));
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		directed_bytes.push_back('{8'h00, 1'b1, ROW_RESULT,
			mk_res(16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, ST_TRUNC)});
		directed_bytes.push_back('{8'hFF, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'hFF, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h00, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h00, 1'b0, ROW_RESULT,
			mk_res(16'hFFFF, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, ST_OK)});
		directed_bytes.push_back('{8'h12, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h34, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h00, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h02, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'hAB, 1'b0, ROW_PREDICT, '0});
		directed_bytes.push_back('{8'hCD, 1'b0, ROW_PREDICT, '0});
		directed_bytes.push_back('{8'h00, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h01, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'hFF, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'hFF, 1'b1, ROW_RESULT,
			mk_res(16'h0001, 16'hFFFF, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, ST_OVERRUN)});
		directed_bytes.push_back('{8'hAA, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h55, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h00, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h03, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'hFF, 1'b1, ROW_PREDICT, '0});
		directed_bytes.push_back('{8'h80, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h00, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h00, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h00, 1'b1, ROW_RESULT,
			mk_res(16'h8000, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, ST_OK)});
		directed_bytes.push_back('{8'h12, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h34, 1'b0, ROW_NONE, '0});
		directed_bytes.push_back('{8'h56, 1'b1, ROW_RESULT,
			mk_res(16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1, ST_TRUNC)});

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i].data_byte, directed_bytes[i].last_byte,
				directed_bytes[i].kind, directed_bytes[i].res);

		for (int phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 28 : (phase == 1) ? 52 : 0;
			sink_idle = (phase == 0) ? 52 : (phase == 1) ? 28 : 0;
			for (int start = bytes_sent; bytes_sent - start < ITEMS_PER_PHASE; )
				send_payload();
		end
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d payloads, %0d bytes in, %0d results checked,", payloads_sent,
			bytes_sent, results_seen);
		$display("incl. clean, truncated, overrun and zero-length records under three stall mixes.");
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
rtl/tlvdf_pkg.sv
rtl/tlv_record_deframer_core.sv
bench/tb_tlv_record_deframer_core.sv
